@@ sv/sevseg_pkg.sv @@
// Shared types, constants and segment decoding for the seven-segment number scanner.
`timescale 1ns / 1ps

package sevseg_pkg;

  localparam int unsigned DefDigitCount = 4;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [7:0]  MinusPattern  = 8'h40;
  localparam logic [16:0] RecipTen      = 17'd52429;  // ceil(2^19 / 10)
  localparam int unsigned RecipShift    = 19;

  typedef enum logic {
    BK_IDLE,
    BK_CONV
  } back_state_e;

  // One request between front and back.
  typedef struct packed {
    logic        is_tick;
    logic        neg;
    logic [15:0] mag;
  } req_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h27;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

@@ sv/sevseg_front.sv @@
// Front end: accepts stream requests and classifies them into queue entries.
`timescale 1ns / 1ps

module sevseg_front
  import sevseg_pkg::*;
(
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] number
  input  logic        s_axis_tuser,   // [0] func
  output logic        push_o,
  output req_t        push_req_o,
  input  logic        full_i
);

  logic [15:0] raw;
  logic        neg;

  assign raw           = s_axis_tdata;
  assign neg           = raw[15];
  assign s_axis_tready = !full_i && rst_ni;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_req_o.is_tick = s_axis_tuser;
    push_req_o.neg     = neg;
    push_req_o.mag     = neg ? (16'd0 - raw) : raw;
  end

endmodule

@@ sv/sevseg_queue.sv @@
// Short request queue between the front and back ends.
`timescale 1ns / 1ps

module sevseg_queue
  import sevseg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  output logic full_o,
  output logic valid_o,
  output req_t req_o,
  input  logic pop_i
);

  req_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign req_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_req_i;
  end

endmodule

@@ sv/sevseg_back.sv @@
// Back end: decimal conversion into the pattern store and scan output register.
`timescale 1ns / 1ps

module sevseg_back
  import sevseg_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DefDigitCount
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  req_t       req_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] select_byte_o,
  output logic [7:0] segment_byte_o,
  output logic [1:0] digit_index_o
);

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(DIGIT_COUNT - 1);

  back_state_e     state_q, state_d;
  logic [7:0]      pattern_q [DIGIT_COUNT];
  logic [PosW-1:0] scan_pos_q, k_q;
  logic            done_q, neg_q, out_valid_q;
  logic [15:0]     mag_q;
  logic [7:0]      sel_q, seg_q;
  logic [1:0]      idx_q;

  logic [32:0]     prod;
  logic [12:0]     quot;
  logic [16:0]     quot_x10;
  logic [3:0]      rem;
  logic            out_free, tick_pop, load_pop;

  // Divide by ten through the reciprocal; exact for 16-bit operands.
  assign prod     = {1'b0, mag_q} * {16'd0, RecipTen};
  assign quot     = prod[RecipShift +: 13];
  assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign rem      = 4'(mag_q - quot_x10[15:0]);

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    tick_pop = 1'b0;
    load_pop = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          if (req_i.is_tick) begin
            tick_pop = out_free;
          end else begin
            load_pop = 1'b1;
            state_d  = BK_CONV;
          end
        end
      end
      BK_CONV: begin
        if (k_q == LastPos) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign pop_o = tick_pop || load_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      scan_pos_q  <= '0;
      k_q         <= '0;
      done_q      <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) pattern_q[i] <= '0;
    end else begin
      if (tick_pop) begin
        out_valid_q <= 1'b1;
        scan_pos_q  <= (scan_pos_q == LastPos) ? '0 : scan_pos_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_pop) begin
        k_q    <= '0;
        done_q <= 1'b0;
      end else if (state_q == BK_CONV) begin
        k_q    <= k_q + 1'b1;
        done_q <= done_q || (quot == '0);
        if (k_q == LastPos && neg_q)
          pattern_q[k_q] <= MinusPattern;
        else
          pattern_q[k_q] <= done_q ? 8'h00 : seg_pattern(rem);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pop) begin
      mag_q <= req_i.mag;
      neg_q <= req_i.neg;
    end else if (state_q == BK_CONV) begin
      mag_q <= {3'b000, quot};
    end
    if (tick_pop) begin
      sel_q <= ~(8'd1 << scan_pos_q);
      seg_q <= ~pattern_q[scan_pos_q];
      idx_q <= 2'(scan_pos_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign select_byte_o  = sel_q;
  assign segment_byte_o = seg_q;
  assign digit_index_o  = idx_q;

endmodule

@@ sv/seven_segment_number_scanner.sv @@
// Top level of the multiplexed seven-segment number scanner.
`timescale 1ns / 1ps

// A request with tuser = 0 loads a signed 16-bit number; with tuser = 1 it is a
// scan tick. A tick returns one result (inverted select byte, inverted segment
// byte, position) and advances the position; ticks are taken one per cycle while
// the result is consumed and no conversion runs. A load returns nothing and
// occupies the back end while it converts, one decimal digit per cycle through
// a reciprocal multiply by one tenth; a two-entry request queue takes up to two
// more requests while a conversion runs, after which the input stalls until it
// ends. Numbers are shown modulo 10^DIGIT_COUNT with leading blanks, and a
// negative value puts a minus sign in the top position.
module seven_segment_number_scanner
  import sevseg_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DefDigitCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] number
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] select_byte, [15:8] segment_byte,
                                      // [17:16] digit_index, [23:18] zero
);

  logic       push, full, q_valid, pop;
  req_t       push_req, q_req;
  logic [7:0] select_byte, segment_byte;
  logic [1:0] digit_index;

  sevseg_front u_front (
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .push_o     (push),
    .push_req_o (push_req),
    .full_i     (full)
  );

  sevseg_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (full),
    .valid_o    (q_valid),
    .req_o      (q_req),
    .pop_i      (pop)
  );

  sevseg_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i,
    .rst_ni,
    .req_valid_i    (q_valid),
    .req_i          (q_req),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .select_byte_o  (select_byte),
    .segment_byte_o (segment_byte),
    .digit_index_o  (digit_index)
  );

  assign m_axis_tdata = {6'd0, digit_index, segment_byte, select_byte};

endmodule

@@ tb/tb.sv @@
// Self-checking stream testbench for the seven-segment number scanner.
`timescale 1ns / 1ps

module tb
  import sevseg_pkg::*;
();

  localparam int unsigned Digits        = DefDigitCount;
  localparam int unsigned NumItems      = 1350;
  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAfter  = 150;
  localparam int unsigned DrainCycles   = (QueueDepth + 1) * (Digits + 1) + 8;

  // Digit patterns 0..9, digit 0 in the low byte.
  localparam logic [79:0] SegRom = {8'h6F, 8'h7F, 8'h27, 8'h7D, 8'h6D,
                                    8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  typedef enum logic {
    FuncLoad = 1'b0,
    FuncTick = 1'b1
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] number;
  } tb_req_t;

  typedef struct packed {
    logic [7:0] select;
    logic [7:0] segment;
    logic [1:0] position;
  } scan_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;    // [15:0] number
  logic        s_axis_tuser  = 1'b0;  // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [7:0] select, [15:8] segment, [17:16] position

  tb_req_t     req_q[$];
  scan_t       scan_q[$];
  logic [7:0]  digit_pat[Digits] = '{default: 8'h00};
  int unsigned scan_pos     = 0;
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cnt     = 0;

  int unsigned burst_left;
  int unsigned gap_left;
  tb_req_t     nxt_req;

  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned hold_left;
  logic        hold_done;
  logic [2:0]  rx_phase;

  seven_segment_number_scanner #(
    .DIGIT_COUNT(Digits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mirror of the display: a load rewrites the patterns, a tick yields one scan result.
  task automatic track_request(input tb_req_t r);
    logic [16:0] mag;
    logic        done;
    int unsigned d;
    int unsigned p;
    scan_t       s;
    if (r.func == FuncLoad) begin
      mag  = r.number[15] ? (17'h10000 - {1'b0, r.number}) : {1'b0, r.number};
      done = 1'b0;
      for (int k = 0; k < Digits; k++) begin
        if (done) begin
          digit_pat[k] = 8'h00;
        end else begin
          d            = mag % 10;
          digit_pat[k] = SegRom[d*8 +: 8];
          mag          = mag / 10;
          if (mag == 0) done = 1'b1;
        end
      end
      if (r.number[15]) digit_pat[Digits-1] = MinusPattern;
    end else begin
      p          = (scan_pos < Digits) ? scan_pos : 0;
      s.select   = ~(8'h01 << p);
      s.segment  = ~digit_pat[p];
      s.position = p[1:0];
      scan_q.push_back(s);
      scan_pos = (p + 1 >= Digits) ? 0 : p + 1;
    end
  endtask

  task automatic push_load(input logic [15:0] n);
    tb_req_t r;
    r.func   = FuncLoad;
    r.number = n;
    req_q.push_back(r);
  endtask

  task automatic push_tick();
    tb_req_t r;
    r.func   = FuncTick;
    r.number = 16'($urandom);
    req_q.push_back(r);
  endtask

  function automatic logic [15:0] rand_number();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 9);
      2: v = $urandom_range(0, 18) - 9;
      3: v = $urandom_range(0, 19998) - 9999;
      4: v = $urandom_range(10000, 32767) * (($urandom_range(0, 1) == 0) ? 1 : -1);
      default: begin
        case ($urandom_range(0, 9))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 0;
          4: v = 9999;
          5: v = -9999;
          6: v = 10000;
          7: v = -1000;
          8: v = 999;
          default: v = -999;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= FuncLoad;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (burst_left == 0 && gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt_req.number;
        s_axis_tuser  <= nxt_req.func;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else if (burst_left == 1) begin
          burst_left <= 0;
          gap_left   <= $urandom_range(1, 8);
        end else begin
          burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: changing ready patterns, plus one long hold-off to back up the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= 0;
      rx_mode_left  <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
      rx_phase      <= '0;
    end else begin
      rx_phase <= rx_phase + 3'd1;
      if (!hold_done && results_seen >= HoldOffAfter) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldOffCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= $urandom_range(0, 3);
          rx_mode_left <= $urandom_range(20, 120);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          2:       m_axis_tready <= ($urandom_range(0, 9) < 2);
          default: m_axis_tready <= (rx_phase[1:0] != 2'd3);
        endcase
      end
    end
  end

  // Monitor: requests feed the mirror first, then results are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_request('{func: func_e'(s_axis_tuser), number: s_axis_tdata});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (scan_q.size() == 0) begin
          $display("%0t: unexpected scan result, expected none, actual %06h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          automatic scan_t exp = scan_q.pop_front();
          if (m_axis_tdata[7:0] !== exp.select) begin
            $display("%0t: select_byte expected %02h actual %02h",
                     $time, exp.select, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[15:8] !== exp.segment) begin
            $display("%0t: segment_byte expected %02h actual %02h",
                     $time, exp.segment, m_axis_tdata[15:8]);
            errors++;
          end
          if (m_axis_tdata[17:16] !== exp.position) begin
            $display("%0t: digit_index expected %0d actual %0d",
                     $time, exp.position, m_axis_tdata[17:16]);
            errors++;
          end
          if (m_axis_tdata[23:18] !== 6'd0) begin
            $display("%0t: tdata padding expected 00 actual %02h",
                     $time, m_axis_tdata[23:18]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    while (idle_cnt < IdleLimit) @(posedge clk_i);
    $display("%0t: timeout, no request or result moved for %0d cycles", $time, IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    // Directed: blank display after reset, zero, most negative, modulo, minus overwrite.
    push_tick();
    push_load(16'd0);
    repeat (Digits) push_tick();
    push_load(16'h8000);
    repeat (Digits) push_tick();
    push_load(16'd12345);
    repeat (Digits) push_tick();
    push_load(-16'sd1234);
    repeat (Digits) push_tick();
    push_load(16'h7FFF);
    push_load(16'hFFFF);
    repeat (Digits) push_tick();

    while (req_q.size() < NumItems) begin
      if ($urandom_range(0, 3) != 0) begin
        push_load(rand_number());
        repeat ($urandom_range(Digits, 2 * Digits)) push_tick();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 2) == 0) push_load(rand_number());
          else push_tick();
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (scan_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0 && scan_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
